@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file ltfr_checker.sv
// depends on nothing; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define LTFR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ltfr assertion failed");

// next-cycle implication, quiet during reset
`define LTFR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ltfr assertion failed");

`endif

@@ hw/rtl/ltfr_pkg.sv @@
// shared constants and types of the line terminated frame receiver
// depends on nothing
package ltfr_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;

    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int RIDX_W   = 6;
    localparam int LIMIT_W  = 8;
    localparam int LEN_W    = 6;
    localparam int STATE_W  = 2;
    localparam int TICK_W   = 16;

    localparam logic [FUNC_W-1:0] FUNC_BYTE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

    localparam logic [STATE_W-1:0] RX_IDLE      = 2'd0;
    localparam logic [STATE_W-1:0] RX_RECEIVING = 2'd1;
    localparam logic [STATE_W-1:0] RX_COMPLETE  = 2'd2;
    localparam logic [STATE_W-1:0] RX_TIMEOUT   = 2'd3;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd100;

    typedef struct packed {
        logic               read_hit;
        logic [LEN_W-1:0]   frame_length;
        logic               frame_ready;
        logic [STATE_W-1:0] rx_state;
    } res_info_t;

endpackage

@@ hw/rtl/ltfr_ifs.sv @@
// valid/ready channel interfaces: input item, result and configuration
// depends on ltfr_pkg
interface ltfr_item_if;
    logic                          valid;
    logic                          ready;
    logic [ltfr_pkg::FUNC_W-1:0]   func;
    logic [ltfr_pkg::BYTE_W-1:0]   rx_byte;
    logic [ltfr_pkg::RIDX_W-1:0]   read_index;
    logic [ltfr_pkg::LIMIT_W-1:0]  read_limit;

    modport source (output valid, func, rx_byte, read_index, read_limit, input ready);
    modport sink   (input valid, func, rx_byte, read_index, read_limit, output ready);
endinterface

interface ltfr_result_if;
    logic                          valid;
    logic                          ready;
    logic [ltfr_pkg::BYTE_W-1:0]   read_byte;
    logic [ltfr_pkg::LEN_W-1:0]    frame_length;
    logic                          frame_ready;
    logic [ltfr_pkg::STATE_W-1:0]  rx_state;

    modport source (output valid, read_byte, frame_length, frame_ready, rx_state,
                    input ready);
    modport sink   (input valid, read_byte, frame_length, frame_ready, rx_state,
                    output ready);
endinterface

interface ltfr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ltfr_pkg::TICK_W-1:0]   timeout_ticks;

    modport source (output valid, timeout_ticks, input ready);
    modport sink   (input valid, timeout_ticks, output ready);
endinterface

@@ hw/rtl/ltfr_ram.sv @@
// generic single write port, single read port ram with registered read
// depends on nothing
module ltfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/ltfr_ctrl.sv @@
// frame control: mode, fill index, ready flag, tick counter and timeout register
// depends on ltfr_pkg; drives the frame store ram ports
module ltfr_ctrl #(
    parameter int BUFFER_DEPTH = ltfr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [ltfr_pkg::FUNC_W-1:0]       func,
    input  logic [ltfr_pkg::BYTE_W-1:0]       rx_byte,
    input  logic [ltfr_pkg::RIDX_W-1:0]       read_index,
    input  logic [ltfr_pkg::LIMIT_W-1:0]      read_limit,
    input  logic                              cfg_we,
    input  logic [ltfr_pkg::TICK_W-1:0]       cfg_data,
    output logic                              wr_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0]   wr_addr,
    output logic [ltfr_pkg::BYTE_W-1:0]       wr_data,
    output logic                              rd_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0]   rd_addr,
    output ltfr_pkg::res_info_t               res
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int LW = (AW > ltfr_pkg::LIMIT_W) ? AW : ltfr_pkg::LIMIT_W;
    localparam logic [AW-1:0] FILL_LAST = AW'(BUFFER_DEPTH - 1);

    typedef enum logic [ltfr_pkg::STATE_W-1:0] {
        MODE_IDLE      = ltfr_pkg::RX_IDLE,
        MODE_RECEIVING = ltfr_pkg::RX_RECEIVING,
        MODE_COMPLETE  = ltfr_pkg::RX_COMPLETE,
        MODE_TIMEOUT   = ltfr_pkg::RX_TIMEOUT
    } mode_t;

    mode_t                         mode_reg, mode_next;
    logic [AW-1:0]                 fill_reg, fill_next, fill_base;
    logic                          ready_reg, ready_next;
    logic [ltfr_pkg::TICK_W-1:0]   elapsed_reg, elapsed_next, elapsed_inc;
    logic [ltfr_pkg::TICK_W-1:0]   timeout_reg;
    logic [LW-1:0]                 fill_w, limit_w, index_w, len;
    logic                          hit;

    assign fill_w  = LW'(fill_reg);
    assign limit_w = LW'(read_limit);
    assign index_w = LW'(read_index);
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg
                                             : ltfr_pkg::TICK_W'(elapsed_reg + 1'b1);

    always_comb
    begin
        mode_next    = mode_reg;
        fill_next    = fill_reg;
        ready_next   = ready_reg;
        elapsed_next = elapsed_reg;
        fill_base    = fill_reg;
        wr_en        = 1'b0;
        len          = '0;
        hit          = 1'b0;
        if (accept)
        begin
            case (func)
                ltfr_pkg::FUNC_BYTE:
                begin
                    if (mode_reg == MODE_IDLE)
                    begin
                        // new frame
                        fill_base    = '0;
                        elapsed_next = '0;
                        mode_next    = MODE_RECEIVING;
                    end
                    if (fill_base < FILL_LAST)
                    begin
                        wr_en     = 1'b1;
                        fill_next = AW'(fill_base + 1'b1);
                        if (rx_byte == ltfr_pkg::CHAR_CR || rx_byte == ltfr_pkg::CHAR_LF)
                        begin
                            ready_next = 1'b1;
                            mode_next  = MODE_COMPLETE;
                        end
                    end
                    else
                    begin
                        // store full, byte dropped
                        fill_next = '0;
                        mode_next = MODE_IDLE;
                    end
                end
                ltfr_pkg::FUNC_TICK:
                begin
                    elapsed_next = elapsed_inc;
                    if (mode_reg == MODE_RECEIVING && elapsed_inc > timeout_reg)
                    begin
                        mode_next = MODE_TIMEOUT;
                        fill_next = '0;
                    end
                end
                ltfr_pkg::FUNC_CLEAR:
                begin
                    ready_next = 1'b0;
                    mode_next  = MODE_IDLE;
                end
                ltfr_pkg::FUNC_READ:
                begin
                    if (ready_reg)
                    begin
                        len = (fill_w > limit_w) ? limit_w : fill_w;
                        hit = index_w < len;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign wr_addr = fill_base;
    assign wr_data = rx_byte;
    assign rd_en   = accept && func == ltfr_pkg::FUNC_READ;
    assign rd_addr = AW'(read_index);

    assign res.read_hit     = hit;
    assign res.frame_length = ltfr_pkg::LEN_W'(len);
    assign res.frame_ready  = ready_next;
    assign res.rx_state     = mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            fill_reg    <= '0;
            ready_reg   <= 1'b0;
            elapsed_reg <= '0;
            timeout_reg <= ltfr_pkg::TIMEOUT_RESET;
        end
        else
        begin
            mode_reg    <= mode_next;
            fill_reg    <= fill_next;
            ready_reg   <= ready_next;
            elapsed_reg <= elapsed_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

endmodule

@@ hw/rtl/ltfr_out.sv @@
// result pipeline: ram read stage and output register with valid/ready handshake
// depends on ltfr_pkg
module ltfr_out (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    output logic                           in_ready,
    input  ltfr_pkg::res_info_t            res,
    input  logic [ltfr_pkg::BYTE_W-1:0]    rd_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ltfr_pkg::BYTE_W-1:0]    read_byte,
    output logic [ltfr_pkg::LEN_W-1:0]     frame_length,
    output logic                           frame_ready,
    output logic [ltfr_pkg::STATE_W-1:0]   rx_state
);

    logic                          s1_valid_reg;
    ltfr_pkg::res_info_t           s1_res_reg;
    logic                          o_valid_reg;
    logic [ltfr_pkg::BYTE_W-1:0]   o_byte_reg;
    logic [ltfr_pkg::LEN_W-1:0]    o_len_reg;
    logic                          o_ready_reg;
    logic [ltfr_pkg::STATE_W-1:0]  o_state_reg;
    logic                          o_adv;

    assign o_adv    = !o_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || o_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (o_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (o_adv)
            begin
                o_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res;
        end
        if (o_adv && s1_valid_reg)
        begin
            o_byte_reg  <= s1_res_reg.read_hit ? rd_data : '0;
            o_len_reg   <= s1_res_reg.frame_length;
            o_ready_reg <= s1_res_reg.frame_ready;
            o_state_reg <= s1_res_reg.rx_state;
        end
    end

    assign out_valid    = o_valid_reg;
    assign read_byte    = o_byte_reg;
    assign frame_length = o_len_reg;
    assign frame_ready  = o_ready_reg;
    assign rx_state     = o_state_reg;

endmodule

@@ hw/rtl/line_terminated_frame_receiver.sv @@
// Line terminated frame receiver.
// item channel: one beat per command (func): received byte, tick, clear ready
//   flag or read of the frame store at read_index, length clipped to read_limit.
// result channel: exactly one beat per item, in order, carrying read_byte,
//   frame_length, frame_ready and rx_state as they stand after that item.
// cfg channel: writes timeout_ticks (reset 100); always ready, write only
//   while no item is in flight.
// throughput: one item per cycle unless the result side stalls; bytes go into
//   the frame store ram at the accepting edge, reads return in the next cycle
//   through its registered read port.
// result path: each item passes the ram read stage, then the output register,
//   from which the result side takes the beat.
// reset: mode idle, fill index, ready flag and tick counter cleared; the
//   frame store is not cleared and needs no clearing pass.
// stall: a held result keeps its beat; one more item is taken into the read
//   stage, after which item ready drops until the result side moves again.
module line_terminated_frame_receiver #(
    parameter int BUFFER_DEPTH = ltfr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ltfr_item_if.sink     item,
    ltfr_result_if.source result,
    ltfr_cfg_if.sink      cfg
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic                          accept;
    logic                          stage_ready;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [ltfr_pkg::BYTE_W-1:0]   wr_data;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic [ltfr_pkg::BYTE_W-1:0]   rd_data;
    ltfr_pkg::res_info_t           res;

    assign item.ready = stage_ready;
    assign accept     = item.valid && stage_ready;
    assign cfg.ready  = 1'b1;

    ltfr_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .func       (item.func),
        .rx_byte    (item.rx_byte),
        .read_index (item.read_index),
        .read_limit (item.read_limit),
        .cfg_we     (cfg.valid),
        .cfg_data   (cfg.timeout_ticks),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .res        (res)
    );

    ltfr_ram #(
        .WIDTH (ltfr_pkg::BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ltfr_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_ready     (stage_ready),
        .res          (res),
        .rd_data      (rd_data),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .read_byte    (result.read_byte),
        .frame_length (result.frame_length),
        .frame_ready  (result.frame_ready),
        .rx_state     (result.rx_state)
    );

endmodule

@@ hw/rtl/ltfr_checker.sv @@
// port level checks of the frame receiver, bound to the top level
// depends on ltfr_pkg and assert_macros.svh
`include "assert_macros.svh"

module ltfr_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [ltfr_pkg::BYTE_W-1:0]    read_byte,
    input  logic [ltfr_pkg::LEN_W-1:0]     frame_length,
    input  logic                           frame_ready,
    input  logic [ltfr_pkg::STATE_W-1:0]   rx_state
);

    // a length is reported only for a ready frame
    `LTFR_ASSERT_IMP(a_len_needs_ready, out_valid && frame_length != '0, frame_ready)

    // a byte from the store implies a non empty reported length
    `LTFR_ASSERT_IMP(a_byte_needs_len, out_valid && read_byte != '0, frame_length != '0)

    // complete frames always carry the ready flag
    `LTFR_ASSERT_IMP(a_complete_ready, out_valid && rx_state == ltfr_pkg::RX_COMPLETE,
        frame_ready)

    // stalled result beat holds
    `LTFR_ASSERT_NXT(a_stall_hold, out_valid && !out_ready,
        out_valid && $stable(read_byte) && $stable(frame_length) && $stable(rx_state))

endmodule

bind line_terminated_frame_receiver ltfr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .read_byte    (result.read_byte),
    .frame_length (result.frame_length),
    .frame_ready  (result.frame_ready),
    .rx_state     (result.rx_state)
);
